// ----- sv/ppct_pkg.sv -----
package ppct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_COORD_W    = 12;
  localparam int LIMIT_W        = 13;
  localparam int CFG_IDX_W      = 2;

  // status and header bit positions
  localparam int STATUS_FULL_BIT = 0;
  localparam int STATUS_AUX_BIT  = 5;
  localparam int HDR_SYNC_BIT    = 3;

  localparam int RESET_X      = 400;
  localparam int RESET_Y      = 300;
  localparam int RESET_WIDTH  = 800;
  localparam int RESET_HEIGHT = 600;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] cursor_x;
    logic [OUT_COORD_W-1:0] cursor_y;
    logic [2:0]             button_bits;
    logic                   byte_taken;
    logic                   packet_done;
  } out_beat_t;

  // command from the packet assembler to the cursor unit
  typedef struct packed {
    logic       taken;
    logic       done;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [2:0] buttons;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/ppct_front.sv -----
module ppct_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enable,
  input  logic              accept,
  input  ppct_pkg::in_beat_t in_data,
  output ppct_pkg::cmd_t     cmd
);
  import ppct_pkg::*;

  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_DX     = 2'd1,
    POS_DY     = 2'd2
  } pos_t;

  pos_t       pos_r, pos_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] dx_r, dx_nxt;
  logic       taken;

  assign taken = enable && in_data.status_byte[STATUS_AUX_BIT]
                        && in_data.status_byte[STATUS_FULL_BIT];

  always_comb begin
    pos_nxt     = pos_r;
    header_nxt  = header_r;
    dx_nxt      = dx_r;
    cmd.taken   = taken;
    cmd.done    = 1'b0;
    cmd.dx      = dx_r;
    cmd.dy      = in_data.data_byte;
    cmd.buttons = header_r[2:0];
    if (taken) begin
      unique case (pos_r)
        POS_DX: begin
          dx_nxt  = in_data.data_byte;
          pos_nxt = POS_DY;
        end
        POS_DY: begin
          cmd.done = 1'b1;
          pos_nxt  = POS_HEADER;
        end
        default: begin
          // header without sync is dropped, wait for another
          header_nxt = in_data.data_byte;
          pos_nxt    = in_data.data_byte[HDR_SYNC_BIT] ? POS_DX : POS_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HEADER;
      header_r <= '0;
      dx_r     <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      header_r <= header_nxt;
      dx_r     <= dx_nxt;
    end
  end

endmodule

// ----- sv/ppct_queue.sv -----
module ppct_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ppct_pkg::q_ctl_t  ctl,
  input  ppct_pkg::cmd_t    wr_cmd,
  output ppct_pkg::cmd_t    rd_cmd,
  output ppct_pkg::q_stat_t stat
);
  import ppct_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign rd_cmd     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (ctl.push) slot_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (ctl.push) wr_ptr_r <= ~wr_ptr_r;
      if (ctl.pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({ctl.push, ctl.pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/ppct_back.sv -----
module ppct_back #(
  parameter int COORD_BITS = ppct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ppct_pkg::LIMIT_W-1:0]  screen_width,
  input  logic [ppct_pkg::LIMIT_W-1:0]  screen_height,
  input  logic                          q_empty,
  input  ppct_pkg::cmd_t                cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppct_pkg::out_beat_t           out_data
);
  import ppct_pkg::*;

  // signed working width: holds coordinate plus an 8-bit step, and any limit
  localparam int SW = (COORD_BITS + 2 > LIMIT_W + 1) ? COORD_BITS + 2 : LIMIT_W + 1;

  logic [COORD_BITS-1:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic [2:0]            buttons_r, buttons_nxt;
  logic                  out_valid_r;
  out_beat_t             out_data_r, out_data_nxt;
  logic signed [SW-1:0]  nx, ny;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                  input logic [LIMIT_W-1:0] lim);
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] top;
    top = SW'(1) <<< COORD_BITS;
    l   = $signed(SW'(lim));
    if (lim == '0) l = SW'(1);
    if (l > top)   l = top;
    if (v < 0)           clamp = '0;
    else if (v >= l)     clamp = COORD_BITS'(l - SW'(1));
    else                 clamp = COORD_BITS'(v);
  endfunction

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  assign nx = $signed(SW'(pos_x_r)) + SW'($signed(cmd.dx));
  assign ny = $signed(SW'(pos_y_r)) - SW'($signed(cmd.dy));

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    buttons_nxt = buttons_r;
    if (cmd.done) begin
      pos_x_nxt   = clamp(nx, screen_width);
      pos_y_nxt   = clamp(ny, screen_height);
      buttons_nxt = cmd.buttons;
    end
    out_data_nxt.cursor_x    = OUT_COORD_W'(pos_x_nxt);
    out_data_nxt.cursor_y    = OUT_COORD_W'(pos_y_nxt);
    out_data_nxt.button_bits = buttons_nxt;
    out_data_nxt.byte_taken  = cmd.taken;
    out_data_nxt.packet_done = cmd.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= COORD_BITS'(RESET_X);
      pos_y_r     <= COORD_BITS'(RESET_Y);
      buttons_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        buttons_r   <= buttons_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/pointer_packet_cursor_tracker.sv -----
// Pointer packet cursor tracker.
// Input channel (in_valid/in_stall/in_data): one beat carries a controller
// status byte and a data byte. Every accepted beat gives exactly one result
// beat on the output channel (out_valid/out_stall/out_data) with the cursor,
// latched buttons and the byte_taken / packet_done flags, in order.
// Configuration: cfg_we with cfg_index (0 enable, 1 width, 2 height) and
// cfg_data, written only while the block is idle; the user must keep to
// this, the block does not enforce it. An accepted beat is queued, then
// popped into the output register. One beat per cycle while out_stall is
// low: the cursor add and clamp are combinational, so the output register
// refills every cycle. A two-entry queue sits between the packet assembler
// and the cursor unit; when the receiver stalls the output register holds,
// the queue fills and in_stall rises once it is full. in_stall never waits
// on a state machine. Synchronous reset (rst_n low): queue and output
// emptied, cursor to (400,300), buttons cleared, assembler back to header
// position, enable 0, width 800, height 600.
module pointer_packet_cursor_tracker #(
  parameter int COORD_BITS = ppct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ppct_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ppct_pkg::out_beat_t            out_data,
  input  logic                           cfg_we,
  input  logic [ppct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppct_pkg::LIMIT_W-1:0]   cfg_data
);
  import ppct_pkg::*;

  logic               enable_r;
  logic [LIMIT_W-1:0] width_r, height_r;
  logic               accept;
  cmd_t               front_cmd, head_cmd;
  q_ctl_t             q_ctl;
  q_stat_t            q_stat;
  logic               q_pop;

  // config registers; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      width_r  <= LIMIT_W'(RESET_WIDTH);
      height_r <= LIMIT_W'(RESET_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // input side only backs up on a full queue
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  assign q_ctl.push = accept;
  assign q_ctl.pop  = q_pop;

  ppct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable  (enable_r),
    .accept  (accept),
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  ppct_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .wr_cmd (front_cmd),
    .rd_cmd (head_cmd),
    .stat   (q_stat)
  );

  ppct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (width_r),
    .screen_height (height_r),
    .q_empty       (q_stat.empty),
    .cmd           (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
